/* sv/ffr_pkg.sv */
`default_nettype none
package ffr_pkg;

	// frame geometry default
	localparam int FFR_FRAME_LEN = 20;

	// header and footer marks
	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] FTR_FIRST  = 8'h55;
	localparam logic [7:0] FTR_SECOND = 8'hAA;

	// width of a payload position on the output
	localparam int IDX_W = 6;

	// readout sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_LOAD  = 3'b100
	} ffr_state_t;

	// load request from the sequencer to the output register
	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] index;
		logic             last;
	} ffr_load_t;

endpackage
`default_nettype wire

/* sv/ffr_store.sv */
`default_nettype none
module ffr_store
	import ffr_pkg::*;
#(
	parameter int DEPTH = FFR_FRAME_LEN - 4,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/ffr_ctrl.sv */
`default_nettype none
module ffr_ctrl
	import ffr_pkg::*;
#(
	parameter int FRAME_LEN = FFR_FRAME_LEN,
	parameter int AW        = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          out_free,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic               mem_re,
	output logic      [AW-1:0] mem_raddr,
	output ffr_load_t          ld
);

	localparam int         DEPTH    = FRAME_LEN - 4;
	localparam logic [5:0] POS_LAST = 6'(FRAME_LEN - 1);
	localparam logic [5:0] POS_FTR  = 6'(FRAME_LEN - 2);
	localparam logic [AW-1:0] K_LAST = AW'(DEPTH - 1);

	ffr_state_t    state_q;
	logic [5:0]    pos_q;
	logic          hdr_ok_q;
	logic          ftr_ok_q;
	logic [AW-1:0] k_q;
	logic          accept;
	logic          frame_good;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign frame_good = hdr_ok_q && ftr_ok_q && (rx_byte == FTR_SECOND);

	// payload bytes go to the store
	assign mem_we = accept && (pos_q != POS_LAST) && (pos_q != 6'd0)
		&& (pos_q != 6'd1) && (pos_q != POS_FTR);
	assign mem_waddr = AW'(pos_q - 6'd2);

	// readout side
	assign mem_re    = (state_q == ST_ISSUE) && out_free;
	assign mem_raddr = k_q;
	assign ld.load   = (state_q == ST_LOAD);
	assign ld.index  = IDX_W'(k_q);
	assign ld.last   = (k_q == K_LAST);

	// frame position and header / footer checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr_ok_q <= 1'b0;
			ftr_ok_q <= 1'b0;
		end else if (accept) begin
			priority if (pos_q == POS_LAST) begin
				pos_q    <= '0;
				hdr_ok_q <= 1'b0;
				ftr_ok_q <= 1'b0;
			end else if (pos_q == 6'd0) begin
				pos_q    <= pos_q + 6'd1;
				hdr_ok_q <= (rx_byte == HDR_FIRST);
				ftr_ok_q <= 1'b0;
			end else if (pos_q == 6'd1) begin
				pos_q    <= pos_q + 6'd1;
				hdr_ok_q <= hdr_ok_q && (rx_byte == HDR_SECOND);
			end else if (pos_q == POS_FTR) begin
				pos_q    <= pos_q + 6'd1;
				ftr_ok_q <= (rx_byte == FTR_FIRST);
			end else begin
				pos_q <= pos_q + 6'd1;
			end
		end
	end

	// readout sequencer: one store read, then one output load, per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (pos_q == POS_LAST) && frame_good) begin
						state_q <= ST_ISSUE;
						k_q     <= '0;
					end
				end
				ST_ISSUE: begin
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (k_q == K_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ISSUE;
						k_q     <= k_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// position never runs past the frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("frame position out of range");

	// every output load follows a store read
	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> $past(mem_re))
		else $error("output load without store read");

	// no store write while a readout runs
	a_no_write_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re || ld.load) |-> !mem_we)
		else $error("store written during readout");
`endif

endmodule
`default_nettype wire

/* sv/fixed_frame_receiver_top.sv */
// readout: the sequencer enters ST_ISSUE in the cycle after a frame's last byte is accepted;
// each payload byte is a store read, then an output load; the read waits until out_free is high.
// throughput: one input byte per cycle outside readout; in_ready is low after a good frame
// until all FRAME_LEN-4 payload bytes have been loaded into the output register.
// reset: arst_n clears position, checks, sequencer and output valid; store is undefined.
`default_nettype none
module fixed_frame_receiver_top
	import ffr_pkg::*;
#(
	parameter int FRAME_LEN = FFR_FRAME_LEN
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       rx_byte,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [7:0]       payload_byte,
	output logic      [IDX_W-1:0] payload_index,
	output logic                  last_byte
);

	localparam int DEPTH = FRAME_LEN - 4;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          out_valid_q;
	logic [7:0]    byte_q;
	logic [IDX_W-1:0] index_q;
	logic          last_q;
	logic          out_free;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	ffr_load_t     ld;

	assign out_free = !out_valid_q || out_ready;

	ffr_ctrl #(
		.FRAME_LEN(FRAME_LEN),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_free(out_free),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.ld(ld)
	);

	ffr_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(rx_byte),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata_q(mem_rdata)
	);

	// output request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ld.load) begin
			byte_q  <= mem_rdata;
			index_q <= ld.index;
			last_q  <= ld.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = byte_q;
	assign payload_index = index_q;
	assign last_byte     = last_q;

`ifndef SYNTHESIS
	// a load only lands in an empty output register
	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> !out_valid_q)
		else $error("output register overwritten");

	// no new input while a result is being loaded
	a_no_input_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> !in_ready)
		else $error("input taken during readout");

	// a last byte is followed by no further load in the next cycle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.load && ld.last) |=> !ld.load)
		else $error("load after last payload byte");
`endif

endmodule
`default_nettype wire
